// File: rtl/wbps_pkg.sv
// Package for the wildcard byte signature scanner.
// Holds sizing constants, register indexes and the transaction and cell types.
// No dependencies.
package wbps_pkg;

	// Signature positions and width of the byte offset counter
	localparam int MAX_PATTERN  = 32;
	localparam int OFFSET_WIDTH = 32;

	localparam int CFG_IDX_WIDTH = 3;
	localparam int CFG_DATA_WIDTH = 64;
	localparam int LEN_WIDTH = 6;
	localparam int MATCH_OFFSET_WIDTH = 32;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		CFG_PAT_0_7   = 3'd0,
		CFG_PAT_8_15  = 3'd1,
		CFG_PAT_16_23 = 3'd2,
		CFG_PAT_24_31 = 3'd3,
		CFG_WILD_MASK = 3'd4,
		CFG_PAT_LEN   = 3'd5
	} cfg_reg_t;

	// Input transaction
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	// Output transaction
	typedef struct packed {
		logic                          found;
		logic [MATCH_OFFSET_WIDTH-1:0] match_offset;
	} out_item_t;

	// Per-cell signature setup
	typedef struct packed {
		logic [7:0] pat_byte;
		logic       wild;
		logic       is_end;
	} cell_cfg_t;

	// Per-cell step control
	typedef struct packed {
		logic advance;
		logic clear;
	} cell_ctl_t;

endpackage

// File: rtl/wbps_cell.sv
// One signature position of the shift-and chain.
// Holds the partial match bit for its position and passes it to the next cell.
// Depends on wbps_pkg.
module wbps_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  wbps_pkg::cell_ctl_t  ctl,
	input  wbps_pkg::cell_cfg_t  cfg,
	input  logic [7:0]           data_byte,
	input  logic                 prev_bit,
	output logic                 bit_q,
	output logic                 hit
);
	import wbps_pkg::*;

	logic nxt_bit;

	// Position matches when prefix matched up to the previous byte
	assign nxt_bit = prev_bit & (cfg.wild | (cfg.pat_byte == data_byte));
	assign hit     = nxt_bit & cfg.is_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= 1'b0;
		end else if (ctl.clear) begin
			bit_q <= 1'b0;
		end else if (ctl.advance) begin
			bit_q <= nxt_bit;
		end
	end

endmodule

// File: rtl/wildcard_byte_pattern_scan_top.sv
// Top level of the wildcard byte signature scanner.
// Holds configuration registers, the cell chain, offset counter and output skid.
// Depends on wbps_pkg and wbps_cell.
//
// Usage:
//   Configuration is written through cfg_valid/cfg_ready with a register index
//   and 64-bit data; cfg_ready is always high. Program the four pattern words,
//   the wildcard mask and the length while no range is in flight.
//   Bytes of a range enter on in_valid/in_stall; last_byte marks the final
//   byte. A transaction is taken when valid is high and stall is low. Each
//   accepted byte is compared by every cell of the chain in parallel; its
//   result is registered in the output register, or in the skid register while
//   the output is stalled. Throughput is one byte per cycle while in_stall is low.
//   At most one result per range: found with the start offset, or not found
//   on the final byte. Later bytes of the range give nothing; the final byte
//   rearms the chain and clears the offset.
//   A stalled result holds in the output register; a second result lands in a
//   skid register, and only then is in_stall raised.
//   Reset clears the chain, offset, flags, registers and the valid bits of both output stages.
module wildcard_byte_pattern_scan_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [wbps_pkg::CFG_IDX_WIDTH-1:0]     cfg_index,
	input  logic [wbps_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  wbps_pkg::in_item_t                     in_item,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output wbps_pkg::out_item_t                    out_item
);
	import wbps_pkg::*;

	localparam logic [LEN_WIDTH-1:0]    MAX_LEN = LEN_WIDTH'(MAX_PATTERN);
	localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAX = '1;

	logic [CFG_DATA_WIDTH-1:0] pat_q [4];
	logic [MAX_PATTERN-1:0]    wild_q;
	logic [LEN_WIDTH-1:0]      len_q;

	logic [LEN_WIDTH-1:0]      eff_len;
	logic [MAX_PATTERN-1:0]    end_sel;
	logic [MAX_PATTERN-1:0]    vec_q;
	logic [MAX_PATTERN-1:0]    hits;
	cell_ctl_t                 ctl;

	logic [OFFSET_WIDTH-1:0]   offset_q;
	logic                      reported_q;
	logic                      accept;
	logic                      hit_any;
	logic                      push;
	out_item_t                 new_item;
	logic [OFFSET_WIDTH-1:0]   back;
	logic [OFFSET_WIDTH-1:0]   start;
	logic [OFFSET_WIDTH+MATCH_OFFSET_WIDTH-1:0] start_ext;

	logic                      out_valid_q;
	out_item_t                 out_item_q;
	logic                      skid_valid_q;
	out_item_t                 skid_item_q;
	logic                      pop;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q[0] <= '0;
			pat_q[1] <= '0;
			pat_q[2] <= '0;
			pat_q[3] <= '0;
			wild_q   <= '0;
			len_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PAT_0_7:   pat_q[0] <= cfg_data;
				CFG_PAT_8_15:  pat_q[1] <= cfg_data;
				CFG_PAT_16_23: pat_q[2] <= cfg_data;
				CFG_PAT_24_31: pat_q[3] <= cfg_data;
				CFG_WILD_MASK: wild_q   <= cfg_data[MAX_PATTERN-1:0];
				CFG_PAT_LEN:   len_q    <= cfg_data[LEN_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// Clamp length and mark the cell that ends the signature
	assign eff_len = (len_q > MAX_LEN) ? MAX_LEN : len_q;

	assign accept      = in_valid && !in_stall;
	assign ctl.advance = accept && !reported_q;
	assign ctl.clear   = accept && in_item.last_byte;

	// Cell chain
	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		cell_cfg_t ccfg;
		logic      prev;

		assign end_sel[i]    = (eff_len == LEN_WIDTH'(i + 1));
		assign ccfg.pat_byte = pat_q[i / 8][(i % 8) * 8 +: 8];
		assign ccfg.wild     = wild_q[i];
		assign ccfg.is_end   = end_sel[i];

		if (i == 0) begin : g_first
			assign prev = 1'b1;
		end else begin : g_rest
			assign prev = vec_q[i-1];
		end

		wbps_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.cfg       (ccfg),
			.data_byte (in_item.data_byte),
			.prev_bit  (prev),
			.bit_q     (vec_q[i]),
			.hit       (hits[i])
		);
	end

	assign hit_any = |hits;

	// Start offset: current offset minus length-1, floored at zero
	assign back      = OFFSET_WIDTH'(eff_len - LEN_WIDTH'(1));
	assign start     = (offset_q >= back) ? (offset_q - back) : '0;
	assign start_ext = {{MATCH_OFFSET_WIDTH{1'b0}}, start};

	assign push = ctl.advance && (hit_any || in_item.last_byte);
	assign new_item.found        = hit_any;
	assign new_item.match_offset = hit_any ? start_ext[MATCH_OFFSET_WIDTH-1:0] : '0;

	// Offset counter and reported flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q   <= '0;
			reported_q <= 1'b0;
		end else if (accept) begin
			if (in_item.last_byte) begin
				offset_q   <= '0;
				reported_q <= 1'b0;
			end else begin
				if (offset_q != OFFSET_MAX) begin
					offset_q <= offset_q + OFFSET_WIDTH'(1);
				end
				if (ctl.advance && hit_any) begin
					reported_q <= 1'b1;
				end
			end
		end
	end

	// Output register with skid stage
	assign pop       = out_valid_q && !out_stall;
	assign in_stall  = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= push;
			end else begin
				out_valid_q  <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_item_q  <= skid_item_q;
				skid_item_q <= new_item;
			end else begin
				out_item_q  <= new_item;
			end
		end else if (push) begin
			skid_item_q <= new_item;
		end
	end

endmodule
